### sv/sfdr_pkg.sv
// Shared types and constants for the serial frame deframer and re-framer.
// Used by sfdr_ctrl, sfdr_dp and the top level; depends on nothing.
package sfdr_pkg;

    // Framing bytes on the receive link
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] STOP_BYTE  = 8'h55;

    // Framing bytes of the forwarded run
    localparam logic [7:0] OPEN_BYTE  = 8'h28;
    localparam logic [7:0] CLOSE_BYTE = 8'h29;
    localparam logic [7:0] ESC_BYTE   = 8'h7E;
    localparam logic [7:0] ADDR_BYTE  = 8'h20;
    localparam logic [7:0] CMD_BYTE   = 8'h40;

    // Sum seed: the header bytes from the start byte onward (AA + 20 + 40)
    localparam logic [15:0] SUM_INIT = 16'h010A;

    // Status reply code range
    localparam logic [7:0] STATUS_MIN = 8'h01;
    localparam logic [7:0] STATUS_MAX = 8'h03;

    // Fixed store positions
    localparam int LEN_POS   = 3;
    localparam int CODE_POS  = 4;
    localparam int CODE2_POS = 5;

    // Header and trailer slot indexes
    localparam logic [2:0] HDR_LAST    = 3'd5;
    localparam logic [1:0] TAIL_SUM_LO = 2'd0;
    localparam logic [1:0] TAIL_SUM_HI = 2'd1;
    localparam logic [1:0] TAIL_STOP   = 2'd2;
    localparam logic [1:0] TAIL_CLOSE  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr;        // restart the store at position 0
        logic put;        // write the received byte into the store
        logic start_emit; // seed the sum and the emit counter
        logic load_hdr;   // load one header byte into the output register
        logic rd;         // read the store at the emit counter
        logic load_body;  // load the read byte into the output register
        logic load_tail;  // load one trailer byte into the output register
    } t_sfdr_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_start;   // received byte is the start byte
        logic fill_full;  // store holds STORE_DEPTH bytes
        logic start_full; // next byte completes the fixed part of the frame
        logic len_bad;    // length byte above the maximum
        logic frame_done; // received byte closes the frame
        logic forward;    // closed frame is to be forwarded
        logic out_free;   // output register can take a byte
        logic hdr_last;   // last header byte
        logic body_last;  // last stored byte of the body
        logic tail_last;  // closing byte
    } t_sfdr_sts;

    // Header bytes of the forwarded run
    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = OPEN_BYTE;
            3'd1:    b = ESC_BYTE;
            3'd2:    b = ESC_BYTE;
            3'd3:    b = START_BYTE;
            3'd4:    b = ADDR_BYTE;
            default: b = CMD_BYTE;
        endcase
        return b;
    endfunction

endpackage

### sv/sfdr_ctrl.sv
// Controller state machine: receive phases and the forwarding sequence.
// Depends on sfdr_pkg; drives commands into sfdr_dp from its status.
module sfdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  sfdr_pkg::t_sfdr_sts i_sts,
    output sfdr_pkg::t_sfdr_cmd o_cmd
);
    import sfdr_pkg::*;

    localparam logic [2:0] S_HUNT  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_RECV  = 3'd2;
    localparam logic [2:0] S_HEAD  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_BODY  = 3'd5;
    localparam logic [2:0] S_TAIL  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_acc;

    // Take input only in the receive phases
    assign o_s_tready = (r_state == S_HUNT) || (r_state == S_START) || (r_state == S_RECV);
    assign w_acc      = i_s_tvalid && o_s_tready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_HUNT: begin
                if (w_acc && i_sts.is_start) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_START;
                end
            end
            S_START, S_RECV: begin
                if (w_acc) begin
                    priority if (i_sts.fill_full) begin
                        // overfilled: resync and treat the byte as a fresh hunt
                        o_cmd.clr = 1'b1;
                        o_cmd.put = i_sts.is_start;
                        n_state   = i_sts.is_start ? S_START : S_HUNT;
                    end else if (r_state == S_START) begin
                        if (i_sts.start_full && i_sts.len_bad) begin
                            o_cmd.clr = 1'b1;
                            n_state   = S_HUNT;
                        end else begin
                            o_cmd.put = 1'b1;
                            if (i_sts.start_full) begin
                                n_state = S_RECV;
                            end
                        end
                    end else if (i_sts.frame_done) begin
                        o_cmd.clr = 1'b1;
                        if (i_sts.forward) begin
                            o_cmd.start_emit = 1'b1;
                            n_state          = S_HEAD;
                        end else begin
                            n_state = S_HUNT;
                        end
                    end else begin
                        o_cmd.put = 1'b1;
                    end
                end
            end
            S_HEAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_hdr = 1'b1;
                    if (i_sts.hdr_last) begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_BODY;
            end
            S_BODY: begin
                if (i_sts.out_free) begin
                    o_cmd.load_body = 1'b1;
                    n_state         = i_sts.body_last ? S_TAIL : S_RD;
                end
            end
            S_TAIL: begin
                if (i_sts.out_free) begin
                    o_cmd.load_tail = 1'b1;
                    if (i_sts.tail_last) begin
                        n_state = S_HUNT;
                    end
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/sfdr_dp.sv
// Datapath: frame store, fill count, length and code bytes, sum and output register.
// Depends on sfdr_pkg; steered by sfdr_ctrl through command and status structs.
module sfdr_dp #(
    parameter int MAX_FRAME_LEN = 20,
    parameter int STORE_DEPTH   = 26
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_fwd,
    input  logic              i_m_tready,
    input  sfdr_pkg::t_sfdr_cmd i_cmd,
    output sfdr_pkg::t_sfdr_sts o_sts,
    output logic              o_m_tvalid,
    output logic [7:0]        o_m_tdata,
    output logic              o_m_tlast
);
    import sfdr_pkg::*;

    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);

    logic [7:0]    r_mem [STORE_DEPTH];
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [AW-1:0] w_wa;
    logic [7:0]    r_len;
    logic [7:0]    r_b4;
    logic [7:0]    r_b5;
    logic [7:0]    w_b5;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_rd_data;
    logic [15:0]   r_sum;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_last;
    logic [7:0]    w_tail;
    logic          w_status;

    // Store write address and fill count
    assign w_wa   = i_cmd.clr ? '0 : r_fill[AW-1:0];
    assign n_fill = (i_cmd.clr ? '0 : r_fill) + FW'(i_cmd.put);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.clr || i_cmd.put) begin
            r_fill <= n_fill;
        end
    end

    // Write the store; keep copies of the length and code bytes
    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_mem[w_wa] <= i_rx_byte;
            if (w_wa == AW'(LEN_POS)) begin
                r_len <= i_rx_byte;
            end
            if (w_wa == AW'(CODE_POS)) begin
                r_b4 <= i_rx_byte;
            end
            if (w_wa == AW'(CODE2_POS)) begin
                r_b5 <= i_rx_byte;
            end
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Frame checks; the second code byte may be the one arriving now
    assign w_b5     = (r_fill == FW'(CODE2_POS)) ? i_rx_byte : r_b5;
    assign w_status = (r_b4 == w_b5) && (r_b4 >= STATUS_MIN) && (r_b4 <= STATUS_MAX);

    assign o_sts.is_start   = (i_rx_byte == START_BYTE);
    assign o_sts.fill_full  = (r_fill == FW'(STORE_DEPTH));
    assign o_sts.start_full = (r_fill == FW'(CODE_POS));
    assign o_sts.len_bad    = (r_len > 8'(MAX_FRAME_LEN));
    assign o_sts.frame_done = (i_rx_byte == STOP_BYTE) &&
                              ((9'(r_fill) + 9'd1) == ({1'b0, r_len} + 9'd2));
    assign o_sts.forward    = w_status || i_fwd;
    assign o_sts.out_free   = !r_out_valid || i_m_tready;
    assign o_sts.hdr_last   = (r_idx[2:0] == HDR_LAST);
    assign o_sts.body_last  = (8'(r_idx) == r_len);
    assign o_sts.tail_last  = (r_idx[1:0] == TAIL_CLOSE);

    // Emit counter and running sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_emit) begin
            r_idx <= '0;
            r_sum <= SUM_INIT;
        end else if (i_cmd.load_hdr) begin
            r_idx <= o_sts.hdr_last ? AW'(LEN_POS) : r_idx + 1'b1;
        end else if (i_cmd.load_body) begin
            r_idx <= o_sts.body_last ? '0 : r_idx + 1'b1;
            r_sum <= r_sum + 16'(r_rd_data);
        end else if (i_cmd.load_tail) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // Trailer byte select
    always_comb begin
        unique case (r_idx[1:0])
            TAIL_SUM_LO: w_tail = r_sum[7:0];
            TAIL_SUM_HI: w_tail = r_sum[15:8];
            TAIL_STOP:   w_tail = STOP_BYTE;
            default:     w_tail = CLOSE_BYTE;
        endcase
    end

    // Output register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_hdr || i_cmd.load_body || i_cmd.load_tail) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load_hdr) begin
            r_out_data <= hdr_byte(r_idx[2:0]);
            r_out_last <= 1'b0;
        end else if (i_cmd.load_body) begin
            r_out_data <= r_rd_data;
            r_out_last <= 1'b0;
        end else if (i_cmd.load_tail) begin
            r_out_data <= w_tail;
            r_out_last <= o_sts.tail_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

### sv/serial_frame_deframe_reframe.sv
// Top level of the serial frame deframer and re-framer: config register and wiring.
// Depends on sfdr_pkg, sfdr_ctrl and sfdr_dp.
//
//  channel   direction  signals                              content
//  s (rx)    in         i_s_tvalid o_s_tready i_s_tdata      rx_byte
//  m (fwd)   out        o_m_tvalid i_m_tready o_m_tdata/tlast out_byte, frame_end
//  apb       in/out     psel penable pwrite paddr pwdata ... forward_other_frames @ 0
//
// Received bytes are handled as they arrive, with no stall. A forwarded frame holds off
// the receive side until its closing byte is loaded; with the sink ready, header bytes
// load one per cycle, and each body byte is read from the store and then loaded.
// Reset (synchronous, active low) returns to hunting with an empty store and
// forwarding of every frame enabled. A stalled sink holds the output register.
module serial_frame_deframe_reframe #(
    parameter int MAX_FRAME_LEN = 20,
    parameter int STORE_DEPTH   = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,   // frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfdr_pkg::*;

    localparam logic CFG_FWD_ADDR = 1'b0;

    logic      r_fwd;
    t_sfdr_cmd w_cmd;
    t_sfdr_sts w_sts;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b1;
        end else if (psel && penable && pwrite && pready && (paddr == CFG_FWD_ADDR)) begin
            r_fwd <= pwdata[0];
        end
    end
    assign prdata = (paddr == CFG_FWD_ADDR) ? 32'(r_fwd) : '0;

    sfdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sfdr_dp #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN),
        .STORE_DEPTH   (STORE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_byte  (i_s_tdata),
        .i_fwd      (r_fwd),
        .i_m_tready (i_m_tready),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef NO_ASSERTIONS
    // The closing byte of a run is always ')'
    a_last_is_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == CLOSE_BYTE))
        else $error("frame_end on a byte other than the closing byte");

    // The store is written only by an accepted receive transfer
    a_put_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.put |-> (i_s_tvalid && o_s_tready))
        else $error("store write without a receive transfer");

    // An accepted byte on a full store always resyncs it
    a_overfill_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && w_sts.fill_full) |=> !w_sts.fill_full)
        else $error("store stayed full after a receive transfer");
`endif

endmodule
